>>> rtl/bts_pkg.sv
// shared constants, types and the rounded lerp for the bilinear texture sampler
// no dependencies
package bts_pkg;

  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_CHANNEL_BITS = 16;

  localparam int CFG_W    = 9;
  localparam int COORD_W  = 19;
  localparam int CLAMP_W  = 17;
  localparam int POS_W    = CLAMP_W + CFG_W;
  localparam int ROW_W    = 2 * CFG_W;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 64;

  localparam logic [0:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [0:0] REG_TEX_HEIGHT = 1'b1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } rgba_t;

  function automatic logic [15:0] lerp16(logic [15:0] a, logic [15:0] b, logic [15:0] f);
    logic [33:0] acc;
    acc = 34'(a) * (34'(17'h10000) - 34'(f)) + 34'(b) * 34'(f) + 34'd32768;
    return acc[31:16];
  endfunction

endpackage

>>> rtl/bts_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module bts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                      rdata_a,
  output logic [WIDTH-1:0]                      rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/bilinear_texture_sampler_core.sv
// bilinear texture sampler with clamp-to-edge addressing, pipelined
// throughput one transaction per cycle while out_tready does not stall the pipeline; only samples reach out_tvalid
// rate set by two dual-read texel rams (copies) serving all four taps each cycle
// reset clears stage valid bits and the size registers; texel rams are not cleared
// depends on bts_pkg and bts_ram
module bilinear_texture_sampler_core #(
  parameter int MAX_WIDTH    = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bts_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNEL_BITS = bts_pkg::DEF_CHANNEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // texel_index, red_in, green_in, blue_in, alpha_in, coord_u, coord_v, zero pad
  input  logic [bts_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [bts_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CB     = CHANNEL_BITS;
  localparam int RAM_W  = 4 * CB;
  localparam int CW     = bts_pkg::CFG_W;

  logic [CW-1:0] tex_w_r, tex_h_r;
  logic [CW-1:0] wc, hc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= '0;
      tex_h_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bts_pkg::REG_TEX_WIDTH:  tex_w_r <= cfg_wdata;
        bts_pkg::REG_TEX_HEIGHT: tex_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign wc = (32'(tex_w_r) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : tex_w_r;
  assign hc = (32'(tex_h_r) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : tex_h_r;

  // stage enables
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  logic en0, en1, en2, en3, en4, en5, en_o;

  assign en_o = !vo_r || out_tready;
  assign en5  = !v5_r || en_o;
  assign en4  = !v4_r || en5;
  assign en3  = !v3_r || en4;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign en0  = !v0_r || en1;
  assign in_tready = en0;

  // input fields
  logic [15:0] in_idx;
  bts_pkg::rgba_t in_texel;
  logic signed [bts_pkg::COORD_W-1:0] in_u, in_v;
  assign in_idx         = in_tdata[15:0];
  assign in_texel.red   = in_tdata[31:16];
  assign in_texel.green = in_tdata[47:32];
  assign in_texel.blue  = in_tdata[63:48];
  assign in_texel.alpha = in_tdata[79:64];
  assign in_u           = in_tdata[98:80];
  assign in_v           = in_tdata[117:99];

  function automatic logic [bts_pkg::CLAMP_W-1:0] clamp_c(
    logic signed [bts_pkg::COORD_W-1:0] c);
    if (c[bts_pkg::COORD_W-1]) begin
      return '0;
    end else if (c > 19'sd65536) begin
      return 17'h10000;
    end
    return c[bts_pkg::CLAMP_W-1:0];
  endfunction

  // stage 0: clamped coordinates
  logic cmd0_r, cmd1_r, cmd2_r, cmd3_r;
  logic [15:0] idx0_r, idx1_r, idx2_r, idx3_r;
  bts_pkg::rgba_t tx0_r, tx1_r, tx2_r, tx3_r;
  logic [bts_pkg::CLAMP_W-1:0] cu0_r, cv0_r;

  always_ff @(posedge clk) begin
    if (en0) begin
      cmd0_r <= in_tuser;
      idx0_r <= in_idx;
      tx0_r  <= in_texel;
      cu0_r  <= clamp_c(in_u);
      cv0_r  <= clamp_c(in_v);
    end
  end

  // stage 1: scaled positions plus one half texel
  logic [bts_pkg::POS_W-1:0] su1_r, sv1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r <= cmd0_r;
      idx1_r <= idx0_r;
      tx1_r  <= tx0_r;
      su1_r  <= bts_pkg::POS_W'(cu0_r) * bts_pkg::POS_W'(wc) + bts_pkg::POS_W'(32768);
      sv1_r  <= bts_pkg::POS_W'(cv0_r) * bts_pkg::POS_W'(hc) + bts_pkg::POS_W'(32768);
    end
  end

  // stage 2: clamped neighbor indexes and fractions
  logic [bts_pkg::POS_W-17:0] ku, kv;
  logic [CW-1:0] xa2_r, xb2_r, ya2_r, yb2_r;
  logic [15:0] fx2_r, fy2_r, fx3_r, fy3_r, fx4_r, fy4_r, fy5_r;

  assign ku = su1_r[bts_pkg::POS_W-1:16];
  assign kv = sv1_r[bts_pkg::POS_W-1:16];

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2_r <= cmd1_r;
      idx2_r <= idx1_r;
      tx2_r  <= tx1_r;
      xa2_r  <= (ku == '0) ? '0 : CW'(ku - 1'b1);
      xb2_r  <= (ku >= {1'b0, wc}) ? CW'(wc - 1'b1) : CW'(ku);
      ya2_r  <= (kv == '0) ? '0 : CW'(kv - 1'b1);
      yb2_r  <= (kv >= {1'b0, hc}) ? CW'(hc - 1'b1) : CW'(kv);
      fx2_r  <= su1_r[15:0];
      fy2_r  <= sv1_r[15:0];
    end
  end

  // stage 3: row base addresses
  logic [bts_pkg::ROW_W-1:0] rowa3_r, rowb3_r;
  logic [CW-1:0] xa3_r, xb3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      cmd3_r  <= cmd2_r;
      idx3_r  <= idx2_r;
      tx3_r   <= tx2_r;
      rowa3_r <= bts_pkg::ROW_W'(ya2_r) * bts_pkg::ROW_W'(wc);
      rowb3_r <= bts_pkg::ROW_W'(yb2_r) * bts_pkg::ROW_W'(wc);
      xa3_r   <= xa2_r;
      xb3_r   <= xb2_r;
      fx3_r   <= fx2_r;
      fy3_r   <= fy2_r;
    end
  end

  // texel rams, written and read as items leave stage 3
  logic [ADDR_W-1:0] a00, a10, a01, a11, waddr;
  logic [RAM_W-1:0] wdata, t00, t10, t01, t11;
  logic we;

  assign a00   = ADDR_W'(bts_pkg::ROW_W'(rowa3_r) + bts_pkg::ROW_W'(xa3_r));
  assign a10   = ADDR_W'(bts_pkg::ROW_W'(rowa3_r) + bts_pkg::ROW_W'(xb3_r));
  assign a01   = ADDR_W'(bts_pkg::ROW_W'(rowb3_r) + bts_pkg::ROW_W'(xa3_r));
  assign a11   = ADDR_W'(bts_pkg::ROW_W'(rowb3_r) + bts_pkg::ROW_W'(xb3_r));
  assign waddr = ADDR_W'(idx3_r);
  assign wdata = {tx3_r.alpha[CB-1:0], tx3_r.blue[CB-1:0],
                  tx3_r.green[CB-1:0], tx3_r.red[CB-1:0]};
  assign we    = v3_r && (cmd3_r == bts_pkg::CMD_WRITE) && en4 && (32'(idx3_r) < DEPTH);

  bts_ram #(.WIDTH(RAM_W), .DEPTH(DEPTH)) u_ram_top (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .re(en4),
    .raddr_a(a00), .raddr_b(a10), .rdata_a(t00), .rdata_b(t10)
  );

  bts_ram #(.WIDTH(RAM_W), .DEPTH(DEPTH)) u_ram_bot (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .re(en4),
    .raddr_a(a01), .raddr_b(a11), .rdata_a(t01), .rdata_b(t11)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      fx4_r <= fx3_r;
      fy4_r <= fy3_r;
    end
  end

  // stage 5: horizontal lerps
  logic [15:0] row0_r [4];
  logic [15:0] row1_r [4];

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int k = 0; k < 4; k++) begin
        row0_r[k] <= bts_pkg::lerp16(16'(t00[k*CB +: CB]), 16'(t10[k*CB +: CB]), fx4_r);
        row1_r[k] <= bts_pkg::lerp16(16'(t01[k*CB +: CB]), 16'(t11[k*CB +: CB]), fx4_r);
      end
      fy5_r <= fy4_r;
    end
  end

  // output stage: vertical lerps, or zero when either texture size is zero
  localparam int OUT_DATA_W_L = bts_pkg::OUT_DATA_W;
  logic [OUT_DATA_W_L-1:0] out_data_r;
  logic zero_size;
  assign zero_size = (wc == '0) || (hc == '0);

  always_ff @(posedge clk) begin
    if (en_o) begin
      for (int k = 0; k < 4; k++) begin
        out_data_r[k*16 +: 16] <= zero_size ? 16'd0
                                 : bts_pkg::lerp16(row0_r[k], row1_r[k], fy5_r);
      end
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r && (cmd3_r == bts_pkg::CMD_SAMPLE);
      if (en5) v5_r <= v4_r;
      if (en_o) vo_r <= v5_r;
    end
  end

endmodule

>>> rtl/bts_checker.sv
// port-level checks for the bilinear texture sampler core, bound to the top level
// depends on bts_pkg and bilinear_texture_sampler_core
module bts_port_checks (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [0:0]                     cfg_index,
  input logic [bts_pkg::CFG_W-1:0]      cfg_wdata,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [bts_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bts_pkg::OUT_DATA_W-1:0] out_tdata
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // nothing left over after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // an empty output stage never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // a draining sink never blocks the input
  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output drains");

endmodule

bind bilinear_texture_sampler_core bts_port_checks u_bts_checker (.*);
